// File: rtl/core/aobo_pkg.sv
// ----------------------------------------------------------------------------
// aobo_pkg
// Shared widths, fixed-point constants and control types for the alpha-over
// blend pipeline.
// ----------------------------------------------------------------------------
package aobo_pkg;

   localparam int PIX_W    = 8;
   localparam int OPA_W    = 17;
   localparam int WEIGHT_W = 24;
   localparam int PROD_W   = PIX_W + WEIGHT_W;
   localparam int QUOT_W   = 16;
   localparam int RECIP_W  = 16;
   localparam int SCALE_W  = QUOT_W + RECIP_W;
   localparam int RECIP_SH = 23;

   // opacity of 1.0 in q1.16
   localparam logic [OPA_W-1:0]    OPACITY_ONE = 17'd65536;
   // 255 * 65536, weight of 1.0
   localparam logic [WEIGHT_W-1:0] ALPHA_DENOM = 24'd16711680;
   // half of the weight denominator, for round half up
   localparam logic [PROD_W-1:0]   HALF_DENOM  = 32'd8355840;
   // ceil(2^23 / 255)
   localparam logic [RECIP_W-1:0]  RECIP_255   = 16'd32897;
   localparam logic [PIX_W-1:0]    PIX_MAX     = 8'd255;

   // load enables of the lane stages
   typedef struct packed {
      logic mul;
      logic sum;
      logic scale;
      logic res;
   } lane_en_type;

endpackage

// File: rtl/core/aobo_lane.sv
// ----------------------------------------------------------------------------
// aobo_lane
// One channel of the blend: x*w + y*(D-w), rounded half up and divided by
// 255*65536 over four register stages.
// ----------------------------------------------------------------------------
module aobo_lane
   import aobo_pkg::*;
(
   input  logic                clock,
   input  lane_en_type         lane_en,
   input  logic [PIX_W-1:0]    src_val,
   input  logic [PIX_W-1:0]    dst_val,
   input  logic [WEIGHT_W-1:0] weight,
   input  logic [WEIGHT_W-1:0] weight_inv,
   output logic [PIX_W-1:0]    result
);

   logic [PROD_W-1:0]  src_prod_ff, src_prod_in;
   logic [PROD_W-1:0]  dst_prod_ff, dst_prod_in;
   logic [QUOT_W-1:0]  quot_ff, quot_in;
   logic [SCALE_W-1:0] scaled_ff, scaled_in;
   logic [PIX_W-1:0]   result_ff, result_in;
   logic [PROD_W-1:0]  sum;
   logic [PIX_W:0]     res_wide;

   always_comb begin
      src_prod_in = PROD_W'(src_val) * PROD_W'(weight);
      dst_prod_in = PROD_W'(dst_val) * PROD_W'(weight_inv);
      sum         = src_prod_ff + dst_prod_ff + HALF_DENOM;
      quot_in     = sum[PROD_W-1:PROD_W-QUOT_W];
      scaled_in   = SCALE_W'(quot_ff) * SCALE_W'(RECIP_255);
      res_wide    = scaled_ff[RECIP_SH+PIX_W:RECIP_SH];
      // saturate
      result_in   = res_wide[PIX_W] ? PIX_MAX : res_wide[PIX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (lane_en.mul) begin
         src_prod_ff <= src_prod_in;
         dst_prod_ff <= dst_prod_in;
      end
      if (lane_en.sum) begin
         quot_ff <= quot_in;
      end
      if (lane_en.scale) begin
         scaled_ff <= scaled_in;
      end
      if (lane_en.res) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// File: rtl/core/alpha_over_blend_opacity.sv
// ----------------------------------------------------------------------------
// alpha_over_blend_opacity
// Porter-Duff over of a straight-alpha rgba8 source onto a destination pixel,
// source alpha scaled by a q1.16 layer opacity.
//
// channel  ports        direction  payload (lowest bits first)
// request  req_t*       in         src r,g,b,a, dst r,g,b,a, 8 bits each
// response rsp_t*       out        out r,g,b,a, 8 bits each
// config   csr_wen/wdata in        opacity, 17 bits, values above 1.0 clamp
//
// one request per cycle while the pipeline is not stalled, through six register stages
// set by weight multiply, weight invert, channel products, rounding sum,
// reciprocal multiply and output register. reset empties the pipeline and
// sets opacity to 1.0. a full stage holds while the stage after it is full and
// stalled; the ready chain is combinational from rsp_tready back to req_tready.
// ----------------------------------------------------------------------------
module alpha_over_blend_opacity
   import aobo_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wen,
   input  logic [OPA_W-1:0] csr_wdata,
   input  logic             req_tvalid,
   output logic             req_tready,
   // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
   input  logic [63:0]      req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // out_red, out_green, out_blue, out_alpha
   output logic [31:0]      rsp_tdata
);

   localparam int STAGES = 6;
   localparam int NCH    = 4;

   logic [OPA_W-1:0] opacity_ff, opacity_in;
   logic [STAGES:1]  vld_ff, vld_in;
   logic [STAGES+1:1] rdy;

   logic [NCH-1:0][PIX_W-1:0] s1_src_ff, s1_dst_ff, s2_src_ff, s2_dst_ff;
   logic [WEIGHT_W-1:0]       s1_w_ff, s1_w_in, s2_w_ff, s2_wi_ff, s2_wi_in;
   logic [PIX_W+OPA_W-1:0]    w_wide;
   logic [NCH-1:0][PIX_W-1:0] lane_res;
   logic [NCH-1:0][PIX_W-1:0] lane_src;
   lane_en_type               lane_en;

   // configuration
   always_comb begin
      opacity_in = (csr_wdata > OPACITY_ONE) ? OPACITY_ONE : csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opacity_ff <= OPACITY_ONE;
      end else if (csr_wen) begin
         opacity_ff <= opacity_in;
      end
   end

   // valid and ready chain
   always_comb begin
      rdy[STAGES+1] = rsp_tready;
      for (int k = STAGES; k >= 1; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in[1] = req_tvalid;
      for (int k = 2; k <= STAGES; k++) begin
         vld_in[k] = vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 1; k <= STAGES; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   // weight stages
   always_comb begin
      w_wide   = (PIX_W+OPA_W)'(req_tdata[31:24]) * (PIX_W+OPA_W)'(opacity_ff);
      s1_w_in  = w_wide[WEIGHT_W-1:0];
      s2_wi_in = ALPHA_DENOM - s1_w_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_w_ff   <= s1_w_in;
         s1_src_ff <= req_tdata[31:0];
         s1_dst_ff <= req_tdata[63:32];
      end
      if (rdy[2]) begin
         s2_w_ff   <= s1_w_ff;
         s2_wi_ff  <= s2_wi_in;
         s2_src_ff <= s1_src_ff;
         s2_dst_ff <= s1_dst_ff;
      end
   end

   // channel lanes
   always_comb begin
      lane_en.mul   = rdy[3];
      lane_en.sum   = rdy[4];
      lane_en.scale = rdy[5];
      lane_en.res   = rdy[6];
      lane_src      = s2_src_ff;
      // alpha uses full coverage as the source term
      lane_src[NCH-1] = PIX_MAX;
   end

   for (genvar c = 0; c < NCH; c++) begin : g_lane
      aobo_lane u_lane (
         .clock      (clock),
         .lane_en    (lane_en),
         .src_val    (lane_src[c]),
         .dst_val    (s2_dst_ff[c]),
         .weight     (s2_w_ff),
         .weight_inv (s2_wi_ff),
         .result     (lane_res[c])
      );
   end

   assign req_tready = rdy[1];
   assign rsp_tvalid = vld_ff[STAGES];
   assign rsp_tdata  = lane_res;

   a_opacity_range: assert property (@(posedge clock) disable iff (reset)
      opacity_ff <= OPACITY_ONE)
      else $error("opacity above one");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[1] |-> s1_w_ff <= ALPHA_DENOM)
      else $error("weight above denominator");

   a_weight_pair: assert property (@(posedge clock) disable iff (reset)
      vld_ff[2] |-> (WEIGHT_W+1)'(s2_w_ff) + (WEIGHT_W+1)'(s2_wi_ff)
                    == (WEIGHT_W+1)'(ALPHA_DENOM))
      else $error("weight and inverse do not sum to one");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[STAGES-1] && !rdy[STAGES]) |=> vld_ff[STAGES-1])
      else $error("stalled stage lost its request");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks alpha_over_blend_opacity against a cycle-free predictor of the
// straight-alpha over blend. A table of hand-picked pixel pairs and opacity
// values comes first, then phases of random pixel pairs at several opacity
// settings, with random stalls on both streams and a quiet tail.
// ----------------------------------------------------------------------------
module testbench;
   import aobo_pkg::*;

   typedef struct packed {
      logic [7:0] alpha;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct packed {
      pixel_type dst;
      pixel_type src;
   } blend_req_type;

   typedef struct packed {
      logic [OPA_W-1:0] opa;
      pixel_type        src;
      pixel_type        dst;
      logic             known;
      pixel_type        want;
   } blend_case_type;

   localparam int N_CASES   = 18;
   localparam int N_PHASES  = 6;
   localparam int PHASE_LEN = 125;

   // pixels written as 32'hAABBGGRR
   blend_case_type blend_cases [N_CASES] = '{
      '{17'd65536,  32'hFF4080C0, 32'h12345678, 1'b1, 32'hFF4080C0},
      '{17'd65536,  32'h00FFFFFF, 32'h80102030, 1'b1, 32'h80102030},
      '{17'd65536,  32'hFFFFFFFF, 32'h00000000, 1'b1, 32'hFFFFFFFF},
      '{17'd65536,  32'h00000000, 32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF},
      '{17'd65536,  32'hFF000000, 32'hFFFFFFFF, 1'b1, 32'hFF000000},
      '{17'd65536,  32'h80FFFFFF, 32'h00000000, 1'b0, 32'h00000000},
      '{17'd65536,  32'h7F123456, 32'h80ABCDEF, 1'b0, 32'h00000000},
      '{17'd0,      32'hFFFFFFFF, 32'h00000000, 1'b1, 32'h00000000},
      '{17'd0,      32'hFF123456, 32'h3C9A5E11, 1'b1, 32'h3C9A5E11},
      '{17'd0,      32'h01FFFFFF, 32'h80808080, 1'b1, 32'h80808080},
      '{17'd131071, 32'hFF4080C0, 32'h12345678, 1'b1, 32'hFF4080C0},
      '{17'd131071, 32'h80AABBCC, 32'h40112233, 1'b0, 32'h00000000},
      '{17'd65537,  32'hFF010203, 32'hFFFFFFFF, 1'b1, 32'hFF010203},
      '{17'd32768,  32'hFF000001, 32'h00000000, 1'b1, 32'h80000001},
      '{17'd32768,  32'h80FFFFFF, 32'h7F000000, 1'b0, 32'h00000000},
      '{17'd1,      32'hFFFFFFFF, 32'h00000000, 1'b1, 32'h00000000},
      '{17'd65535,  32'hFF000000, 32'hFFFFFFFF, 1'b0, 32'h00000000},
      '{17'd65536,  32'h01FF00FF, 32'hFE00FF00, 1'b0, 32'h00000000}
   };

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             csr_wen    = 1'b0;
   logic [OPA_W-1:0] csr_wdata  = '0;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [63:0]      req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [31:0]      rsp_tdata;

   pixel_type        blend_expect_q [$];
   logic [OPA_W-1:0] opacity_copy = OPACITY_ONE;
   logic             quiet        = 1'b0;
   int               ready_burst  = 0;
   int               mismatches   = 0;
   int               sent_count   = 0;
   int               rsp_count    = 0;
   int               opa_writes   = 0;
   pixel_type        rsp_got;
   pixel_type        rsp_want;

   alpha_over_blend_opacity u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] mix_lane(input logic [7:0] x, input logic [7:0] y,
                                           input logic [63:0] w);
      logic [63:0] num;
      logic [63:0] r;
      num = 64'(x) * w + 64'(y) * (64'(ALPHA_DENOM) - w);
      r   = (2 * num + 64'(ALPHA_DENOM)) / (2 * 64'(ALPHA_DENOM));
      return (r > 64'(PIX_MAX)) ? PIX_MAX : r[7:0];
   endfunction

   function automatic pixel_type blend_over(input pixel_type src, input pixel_type dst,
                                            input logic [OPA_W-1:0] opa);
      logic [63:0] w;
      pixel_type   p;
      w       = 64'(src.alpha) * 64'((opa > OPACITY_ONE) ? OPACITY_ONE : opa);
      p.red   = mix_lane(src.red, dst.red, w);
      p.green = mix_lane(src.green, dst.green, w);
      p.blue  = mix_lane(src.blue, dst.blue, w);
      p.alpha = mix_lane(PIX_MAX, dst.alpha, w);
      return p;
   endfunction

   task automatic send_request(input blend_req_type item, input pixel_type want);
      logic taken;
      req_tvalid <= 1'b1;
      req_tdata  <= item;
      forever begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
         if (taken) break;
      end
      blend_expect_q.insert(blend_expect_q.size(), want);
      sent_count++;
   endtask

   task automatic request_gap();
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // opacity only changes once the pipeline has drained
   task automatic set_opacity(input logic [OPA_W-1:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (blend_expect_q.size() != 0) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen      <= 1'b0;
      opacity_copy = value;
      opa_writes++;
   endtask

   // response side backpressure
   always @(posedge clock) begin
      if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (ready_burst == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            rsp_tready  <= 1'b0;
            ready_burst <= $urandom_range(0, 18);
         end else begin
            rsp_tready  <= 1'b1;
            ready_burst <= $urandom_range(0, 30);
         end
      end else begin
         ready_burst <= ready_burst - 1;
      end
   end

   // values are stable between edges, so a handshake seen here lands at the next edge
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_got = rsp_tdata;
         rsp_count++;
         if (blend_expect_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response %h with no request outstanding", rsp_got);
         end else begin
            rsp_want = blend_expect_q.pop_front();
            if (rsp_got.red !== rsp_want.red || rsp_got.green !== rsp_want.green ||
                rsp_got.blue !== rsp_want.blue || rsp_got.alpha !== rsp_want.alpha) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"response %0d: expected r=%0d g=%0d b=%0d a=%0d, ",
                            "got r=%0d g=%0d b=%0d a=%0d"},
                           rsp_count, rsp_want.red, rsp_want.green, rsp_want.blue,
                           rsp_want.alpha, rsp_got.red, rsp_got.green, rsp_got.blue,
                           rsp_got.alpha);
            end
         end
      end
   end

   initial begin
      #4_000_000;
      $display("alpha_over_blend_opacity: mismatch");
      $finish;
   end

   initial begin
      blend_req_type    item;
      pixel_type        want;
      logic [OPA_W-1:0] opa;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_CASES; i++) begin
         if (blend_cases[i].opa != opacity_copy)
            set_opacity(blend_cases[i].opa);
         item.src = blend_cases[i].src;
         item.dst = blend_cases[i].dst;
         want = blend_cases[i].known ? blend_cases[i].want
                                     : blend_over(item.src, item.dst, opacity_copy);
         send_request(item, want);
         request_gap();
      end

      for (int ph = 0; ph < N_PHASES; ph++) begin
         case (ph)
            0: opa = 17'($urandom_range(0, 65536));
            1: opa = OPACITY_ONE;
            2: opa = 17'($urandom_range(65537, 131071));
            3: opa = '0;
            4: opa = 17'($urandom_range(1, 65535));
            default: opa = 17'($urandom_range(0, 131071));
         endcase
         set_opacity(opa);
         if (ph == N_PHASES - 1)
            quiet = 1'b1;
         for (int n = 0; n < PHASE_LEN; n++) begin
            item = {$urandom(), $urandom()};
            case ($urandom_range(0, 7))
               0: item.src.alpha = 8'd0;
               1: item.src.alpha = PIX_MAX;
               2: item.dst.alpha = $urandom_range(0, 1) ? PIX_MAX : 8'd0;
               default: ;
            endcase
            send_request(item, blend_over(item.src, item.dst, opacity_copy));
            request_gap();
         end
      end

      req_tvalid <= 1'b0;
      while (blend_expect_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (blend_expect_q.size() != 0)
         mismatches++;

      $display("%0d requests blended, %0d responses checked, %0d opacity writes",
               sent_count, rsp_count, opa_writes);
      $display("opacity covered zero, one, clamped above one and random levels");
      if (mismatches == 0)
         $display("alpha_over_blend_opacity: match");
      else
         $display("alpha_over_blend_opacity: mismatch");
      $finish;
   end

endmodule

// File: files.f
rtl/core/aobo_pkg.sv
rtl/core/aobo_lane.sv
rtl/core/alpha_over_blend_opacity.sv
sim/testbench.sv
